// ===== src/bbsc_pkg.sv =====
`default_nettype none

package bbsc_pkg;

   // Row geometry and lane split
   localparam int ROW_BITS   = 32;
   localparam int NUM_LANES  = 4;
   localparam int LANE_BITS  = ROW_BITS / NUM_LANES;
   localparam int LANE_CNT_W = $clog2(LANE_BITS + 1);
   localparam int CNT_W      = $clog2(ROW_BITS + 1);
   localparam int WIDTH_W    = 6;
   localparam int ROWS_W     = 7;
   localparam logic [ROWS_W-1:0] ROWS_SAT = 7'd127;
   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd32;
   localparam int RSP_DATA_W = 8;

   typedef logic [LANE_CNT_W-1:0] lane_cnt_type;
   typedef logic [CNT_W-1:0]      row_cnt_type;

   // Position relative to the first run of non-empty rows
   typedef enum logic [2:0] {
      PH_BEFORE = 3'b001,
      PH_IN     = 3'b010,
      PH_AFTER  = 3'b100
   } phase_type;

   // Control that travels with the lane counts into the merge stage
   typedef struct packed {
      logic valid;
      logic last;
   } step_type;

endpackage

`default_nettype wire

// ===== src/binary_blob_shape_classifier_top.sv =====
// Binary blob shape classifier.
// An image enters one row per item on the req_ channel: tdata carries the 32
// pixels of the row (bit j is column j), tlast marks the final row. Only the
// low csr_wr_data columns count; the user must write this width via csr_wr_en
// only while the block is idle (not enforced by the block); reset makes it 32.
// The block follows the first run of non-empty rows. On the final row it
// sends one item on the rsp_ channel: tdata bit 0 is square (all rows of
// the run have equal counts and the run length equals that count), bit 1
// is triangle (counts strictly rise or strictly fall). An empty image
// gives neither. Rows that are not final give no result.
// Throughput is one row per clock unless a final row waits for a free result
// slot. Each row is split over four popcount lanes, registered when the row
// is accepted; the merge stage adds the lane counts and updates the run
// tracker as the row leaves the lanes, when a final row also sets rsp_tvalid.
// When the receiver stalls, the result waits in the output register and
// rows keep entering until a second final row waits in the lane registers,
// which then holds req_tready low. Reset clears the run tracker and drops
// any pending result.
`default_nettype none

module binary_blob_shape_classifier_top #(
   parameter int MAX_COLS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [bbsc_pkg::ROW_BITS-1:0]   req_tdata,   // row_bits
   input  wire logic                            req_tlast,   // last_row
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [bbsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // is_square, is_triangle, zeros
   input  wire logic                            csr_wr_en,
   input  wire logic [bbsc_pkg::WIDTH_W-1:0]    csr_wr_data  // row_width
);

   localparam int COL_LIM = (MAX_COLS < bbsc_pkg::ROW_BITS) ? MAX_COLS : bbsc_pkg::ROW_BITS;

   logic [bbsc_pkg::WIDTH_W-1:0]  width_ff;
   logic [bbsc_pkg::WIDTH_W-1:0]  eff_width;
   logic [bbsc_pkg::ROW_BITS-1:0] mask;
   logic [bbsc_pkg::ROW_BITS-1:0] masked;
   logic                          lane_valid_ff, lane_valid_in;
   logic                          lane_last_ff;
   logic                          out_free;
   logic                          lane_move;
   logic                          accept;
   bbsc_pkg::step_type            step;
   logic [bbsc_pkg::NUM_LANES-1:0][bbsc_pkg::LANE_CNT_W-1:0] lane_counts;
   logic                          square;
   logic                          triangle;

   // Row width register
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= bbsc_pkg::WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   // Clamp the width and mask the unused columns
   assign eff_width = (width_ff > bbsc_pkg::WIDTH_W'(COL_LIM)) ?
                      bbsc_pkg::WIDTH_W'(COL_LIM) : width_ff;

   always_comb begin
      for (int j = 0; j < bbsc_pkg::ROW_BITS; j++) begin
         mask[j] = (bbsc_pkg::WIDTH_W'(j) < eff_width);
      end
   end

   assign masked = req_tdata & mask;

   // Flow control: a final row leaves the lanes only into a free result slot
   assign out_free   = !rsp_tvalid || rsp_tready;
   assign lane_move  = lane_valid_ff && (!lane_last_ff || out_free);
   assign req_tready = !lane_valid_ff || lane_move;
   assign accept     = req_tvalid && req_tready;

   assign lane_valid_in = accept || (lane_valid_ff && !lane_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= lane_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lane_last_ff <= req_tlast;
      end
   end

   // Popcount lanes
   for (genvar g = 0; g < bbsc_pkg::NUM_LANES; g++) begin : g_lane
      bbsc_lane u_lane (
         .clock    (clock),
         .load     (accept),
         .bits     (masked[g*bbsc_pkg::LANE_BITS +: bbsc_pkg::LANE_BITS]),
         .count_ff (lane_counts[g])
      );
   end

   // Merge lanes and track the run
   assign step.valid = lane_move;
   assign step.last  = lane_last_ff;

   bbsc_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .lane_counts  (lane_counts),
      .out_taken    (rsp_tready),
      .out_valid_ff (rsp_tvalid),
      .square_ff    (square),
      .triangle_ff  (triangle)
   );

   assign rsp_tdata = {{(bbsc_pkg::RSP_DATA_W-2){1'b0}}, triangle, square};

endmodule

`default_nettype wire

// ===== src/bbsc_lane.sv =====
`default_nettype none

module bbsc_lane (
   input  wire logic                            clock,
   input  wire logic                            load,
   input  wire logic [bbsc_pkg::LANE_BITS-1:0]  bits,
   output bbsc_pkg::lane_cnt_type               count_ff
);

   bbsc_pkg::lane_cnt_type count_in;

   // Count the set pixels of this lane's slice
   always_comb begin
      count_in = '0;
      for (int j = 0; j < bbsc_pkg::LANE_BITS; j++) begin
         count_in = count_in + bbsc_pkg::lane_cnt_type'(bits[j]);
      end
   end

   // Hold the count until the merge stage takes it
   always_ff @(posedge clock) begin
      if (load) begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/bbsc_merge.sv =====
`default_nettype none

module bbsc_merge (
   input  wire logic                                             clock,
   input  wire logic                                             reset,
   input  wire bbsc_pkg::step_type                               step,
   input  wire logic [bbsc_pkg::NUM_LANES-1:0][bbsc_pkg::LANE_CNT_W-1:0] lane_counts,
   input  wire logic                                             out_taken,
   output logic                                                  out_valid_ff,
   output logic                                                  square_ff,
   output logic                                                  triangle_ff
);

   bbsc_pkg::phase_type   phase_ff, phase_in;
   logic [bbsc_pkg::ROWS_W-1:0] rows_ff, rows_in;
   bbsc_pkg::row_cnt_type first_ff, first_in;
   bbsc_pkg::row_cnt_type prev_ff, prev_in;
   logic                  mism_ff, mism_in;
   logic                  rising_ff, rising_in;
   logic                  falling_ff, falling_in;
   bbsc_pkg::row_cnt_type count;
   logic                  out_valid_in;
   logic                  square_in;
   logic                  triangle_in;

   // Add the lane counts
   always_comb begin
      count = '0;
      for (int k = 0; k < bbsc_pkg::NUM_LANES; k++) begin
         count = count + bbsc_pkg::row_cnt_type'(lane_counts[k]);
      end
   end

   // Advance the run tracker by one row
   always_comb begin
      phase_in   = phase_ff;
      rows_in    = rows_ff;
      first_in   = first_ff;
      prev_in    = prev_ff;
      mism_in    = mism_ff;
      rising_in  = rising_ff;
      falling_in = falling_ff;
      unique case (phase_ff)
         bbsc_pkg::PH_BEFORE: begin
            if (count != '0) begin
               phase_in   = bbsc_pkg::PH_IN;
               rows_in    = bbsc_pkg::ROWS_W'(1);
               first_in   = count;
               prev_in    = count;
               mism_in    = 1'b0;
               rising_in  = 1'b1;
               falling_in = 1'b1;
            end
         end
         bbsc_pkg::PH_IN: begin
            if (count == '0) begin
               phase_in = bbsc_pkg::PH_AFTER;
            end else begin
               if (rows_ff != bbsc_pkg::ROWS_SAT) begin
                  rows_in = rows_ff + bbsc_pkg::ROWS_W'(1);
               end
               if (count != first_ff) mism_in = 1'b1;
               if (count <= prev_ff) rising_in = 1'b0;
               if (count >= prev_ff) falling_in = 1'b0;
               prev_in = count;
            end
         end
         bbsc_pkg::PH_AFTER: begin
         end
         default: begin
            phase_in = bbsc_pkg::PH_AFTER;
         end
      endcase
   end

   // Classify the run on the last row
   always_comb begin
      if (phase_in == bbsc_pkg::PH_BEFORE) begin
         square_in   = 1'b0;
         triangle_in = 1'b0;
      end else begin
         square_in   = !mism_in &&
                       (rows_in == bbsc_pkg::ROWS_W'(first_in));
         triangle_in = rising_in || falling_in;
      end
   end

   // Hold a result until taken; a last row arrives only when the slot is free
   assign out_valid_in = (step.valid && step.last) || (out_valid_ff && !out_taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= bbsc_pkg::PH_BEFORE;
         rows_ff      <= '0;
         first_ff     <= '0;
         prev_ff      <= '0;
         mism_ff      <= 1'b0;
         rising_ff    <= 1'b1;
         falling_ff   <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (step.valid) begin
            if (step.last) begin
               phase_ff   <= bbsc_pkg::PH_BEFORE;
               rows_ff    <= '0;
               first_ff   <= '0;
               prev_ff    <= '0;
               mism_ff    <= 1'b0;
               rising_ff  <= 1'b1;
               falling_ff <= 1'b1;
            end else begin
               phase_ff   <= phase_in;
               rows_ff    <= rows_in;
               first_ff   <= first_in;
               prev_ff    <= prev_in;
               mism_ff    <= mism_in;
               rising_ff  <= rising_in;
               falling_ff <= falling_in;
            end
         end
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (step.valid && step.last) begin
         square_ff   <= square_in;
         triangle_ff <= triangle_in;
      end
   end

endmodule

`default_nettype wire
